// ===== rtl/core/hrcs_pkg.sv =====
package hrcs_pkg;

  localparam int FREQ_W  = 26;
  localparam int BW_W    = 16;
  localparam int HASH_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam int DVD_W   = HASH_W;
  localparam int DVS_W   = FREQ_W;
  localparam int DCNT_W  = $clog2(DVD_W);

  localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
  localparam logic [FREQ_W-1:0] FREQ_MAX  = {FREQ_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH  = 2'd3;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_ctl_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DVD_W-1:0]  quotient;
    logic [DVS_W-1:0]  remainder;
  } div_sts_t;

endpackage

// ===== rtl/core/hrcs_divider.sv =====
module hrcs_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  hrcs_pkg::div_ctl_t ctl,
  output hrcs_pkg::div_sts_t sts
);
  import hrcs_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    rem_r, rem_nxt;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem_r[DVS_W-1:0], dvd_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = ctl.dividend;
      dvs_nxt  = ctl.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy      = busy_r;
  assign sts.done      = done_r;
  assign sts.quotient  = dvd_r;
  assign sts.remainder = rem_r[DVS_W-1:0];

endmodule

// ===== rtl/core/hashed_radio_channel_select_unit.sv =====
// A byte not marked last is hashed in its accept cycle; the next may follow at once.
// A byte marked last starts its item: 32 divider steps for the count, one reload and 32
// steps for hash modulo count, then remainder, multiply and output load.
// Throughput: one byte per cycle inside a name; after a last byte the next is taken only once
// its item is loaded for output, later still while the previous item waits for out_ready.
// Reset (rst_n synchronous, active low): config registers to 0, running hash to 5381, no item held.
module hashed_radio_channel_select_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [hrcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hrcs_pkg::FREQ_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hrcs_pkg::BYTE_W-1:0]    in_name_byte,
  input  logic                          in_name_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hrcs_pkg::FREQ_W-1:0]    out_channel_index,
  output logic [hrcs_pkg::FREQ_W-1:0]    out_centre_frequency,
  output logic [hrcs_pkg::HASH_W-1:0]    out_name_hash
);
  import hrcs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam int PROD_W = FREQ_W + BW_W;
  localparam int SUM_W  = PROD_W + 1;

  logic [FREQ_W-1:0] band_start_r, band_end_r;
  logic [BW_W-1:0]   spacing_r, bandwidth_r;

  logic [2:0]        state_r, state_nxt;
  logic [HASH_W-1:0] run_hash_r, run_hash_nxt;
  logic [HASH_W-1:0] fin_hash_r, fin_hash_nxt;
  logic [FREQ_W-1:0] count_r, count_nxt;
  logic [FREQ_W-1:0] idx_r, idx_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [FREQ_W-1:0] out_idx_r, out_idx_nxt;
  logic [FREQ_W-1:0] out_freq_r, out_freq_nxt;
  logic [HASH_W-1:0] out_hash_r, out_hash_nxt;

  logic              in_acc;
  logic [HASH_W-1:0] hash_new;
  logic [BW_W:0]     div_sum;
  logic              degenerate;
  logic [FREQ_W-1:0] count_q;
  logic [SUM_W-1:0]  centre_sum;
  logic              out_free;

  div_ctl_t div_ctl;
  div_sts_t div_sts;

  hrcs_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (div_ctl),
    .sts  (div_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_start_r <= '0;
      band_end_r   <= '0;
      spacing_r    <= '0;
      bandwidth_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BAND_START: band_start_r <= cfg_wdata;
        CFG_BAND_END:   band_end_r   <= cfg_wdata;
        CFG_SPACING:    spacing_r    <= cfg_wdata[BW_W-1:0];
        CFG_BANDWIDTH:  bandwidth_r  <= cfg_wdata[BW_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign hash_new   = (run_hash_r << 5) + run_hash_r + {{(HASH_W-BYTE_W){1'b0}}, in_name_byte};
  assign div_sum    = {1'b0, spacing_r} + {1'b0, bandwidth_r};
  assign degenerate = (div_sum == '0) || (band_end_r < band_start_r);
  assign count_q    = (degenerate || (div_sts.quotient == '0))
                      ? FREQ_W'(1) : div_sts.quotient[FREQ_W-1:0];
  assign centre_sum = {{(SUM_W-FREQ_W){1'b0}}, band_start_r}
                    + {{(SUM_W-BW_W+1){1'b0}}, bandwidth_r[BW_W-1:1]}
                    + {1'b0, prod_r};
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    run_hash_nxt  = run_hash_r;
    fin_hash_nxt  = fin_hash_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_freq_nxt  = out_freq_r;
    out_hash_nxt  = out_hash_r;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = {{(DVD_W-FREQ_W){1'b0}}, band_end_r - band_start_r};
    div_ctl.divisor  = {{(DVS_W-BW_W-1){1'b0}}, div_sum};
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_name_last) begin
            fin_hash_nxt  = hash_new;
            run_hash_nxt  = HASH_SEED;
            div_ctl.start = 1'b1;
            state_nxt     = S_DIV1;
          end else begin
            run_hash_nxt = hash_new;
          end
        end
      end
      S_DIV1: begin
        if (div_sts.done) begin
          count_nxt        = count_q;
          div_ctl.start    = 1'b1;
          div_ctl.dividend = fin_hash_r;
          div_ctl.divisor  = count_q;
          state_nxt        = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_sts.done) begin
          idx_nxt   = div_sts.remainder;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = idx_r * bandwidth_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_freq_nxt  = (centre_sum[SUM_W-1:FREQ_W] != '0)
                          ? FREQ_MAX : centre_sum[FREQ_W-1:0];
          out_hash_nxt  = fin_hash_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_hash_r  <= HASH_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_hash_r  <= run_hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fin_hash_r <= fin_hash_nxt;
    count_r    <= count_nxt;
    idx_r      <= idx_nxt;
    prod_r     <= prod_nxt;
    out_idx_r  <= out_idx_nxt;
    out_freq_r <= out_freq_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_channel_index    = out_idx_r;
  assign out_centre_frequency = out_freq_r;
  assign out_name_hash        = out_hash_r;

  a_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_name_last) |=> (run_hash_r == HASH_SEED))
    else $error("running hash not reseeded after last item");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (idx_r < count_r))
    else $error("channel index not below channel count");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_sts.busy)
    else $error("divider busy while idle");

  a_div2_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV2 && div_sts.done) |=> (state_r == S_MUL))
    else $error("missed divider completion");

endmodule
